// File: hdl/plh_pkg.sv
// package for the positional list engine
// holds command and status codes, cell control type and default sizes
// no dependencies
`default_nettype none

package plh_pkg;

   // default number of list entries
   localparam int DEPTH_DEFAULT = 16;

   // fixed field widths
   localparam int CMD_W  = 3;
   localparam int DATA_W = 32;
   localparam int POS_W  = 5;
   localparam int STAT_W = 2;
   localparam int LEN_W  = 5;

   // command codes
   localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_TAIL  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE_AT = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REPLACE   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd5;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

   // broadcast control for the cell row
   typedef struct packed {
      logic ins;   // open a slot at pos, cells above take the left neighbor
      logic del;   // close the slot at pos, cells at and above take the right neighbor
      logic wr;    // overwrite the cell at pos
   } plh_ctl_type;

endpackage

`default_nettype wire

// File: hdl/plh_cell.sv
// one storage cell of the list row
// holds a single entry and shifts with its neighbors; uses plh_pkg
`default_nettype none

module plh_cell #(
   parameter int PW    = 5,
   parameter int INDEX = 0
) (
   input  wire                          clock,
   input  plh_pkg::plh_ctl_type         ctl,
   input  wire  [PW-1:0]                pos,
   input  wire  [plh_pkg::DATA_W-1:0]   value_i,
   input  wire  [plh_pkg::DATA_W-1:0]   left_i,
   input  wire  [plh_pkg::DATA_W-1:0]   right_i,
   output logic [plh_pkg::DATA_W-1:0]   entry_o
);
   import plh_pkg::*;

   localparam logic [PW-1:0] MY_IDX = PW'(INDEX);

   logic [DATA_W-1:0] entry_ff;
   logic [DATA_W-1:0] entry_in;
   logic              at_pos;
   logic              above_pos;

   assign at_pos    = (MY_IDX == pos);
   assign above_pos = (MY_IDX > pos);

   // next entry value from the broadcast command
   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins) begin
         if (at_pos) entry_in = value_i;
         else if (above_pos) entry_in = left_i;
      end else if (ctl.del) begin
         if (at_pos || above_pos) entry_in = right_i;
      end else if (ctl.wr) begin
         if (at_pos) entry_in = value_i;
      end
   end

   // entry storage, contents undefined until written
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_o = entry_ff;

endmodule

`default_nettype wire

// File: hdl/positional_list_engine.sv
// Latency: the first result of a request comes on the cycle after it is accepted.
// Throughput: one request per cycle for every command except dump; a dump of
// n entries gives n results, one per cycle, and holds busy while the rest are read,
// as the single read port walks the cell row one entry a cycle.
// Reset (synchronous) empties the list; entry contents stay undefined until written.
// Results cannot be stalled: rsp_valid marks each one for exactly one cycle.
// top level of the positional list engine: control, read mux and the cell row
// depends on plh_pkg and plh_cell
`default_nettype none

module positional_list_engine #(
   parameter int DEPTH = plh_pkg::DEPTH_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire         [plh_pkg::CMD_W-1:0]    req_command,
   input  wire  signed [plh_pkg::DATA_W-1:0]   req_value,
   input  wire         [plh_pkg::POS_W-1:0]    req_position,
   output logic                                rsp_valid,
   output logic        [plh_pkg::STAT_W-1:0]   rsp_status,
   output logic        [plh_pkg::LEN_W-1:0]    rsp_length,
   output logic signed [plh_pkg::DATA_W-1:0]   rsp_data,
   output logic                                rsp_last
);
   import plh_pkg::*;

   // count width holds DEPTH itself; compare width also covers a 5-bit position
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;
   localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

   // control registers
   logic [CW-1:0]     count_ff, count_in;
   logic              busy_ff, busy_in;
   logic [CW-1:0]     dump_idx_ff, dump_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   // result payload registers
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]  rsp_length_ff, rsp_length_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic [PW-1:0]     count_p;
   logic [PW-1:0]     req_pos_p;
   logic [PW-1:0]     cell_pos;
   logic [PW-1:0]     rd_idx;
   logic [DATA_W-1:0] rd_data;
   plh_ctl_type       ctl;

   logic [DATA_W-1:0] cell_q     [DEPTH];
   logic [DATA_W-1:0] cell_left  [DEPTH];
   logic [DATA_W-1:0] cell_right [DEPTH];

   assign accept    = start && !busy_ff;
   assign count_p   = PW'(count_ff);
   assign req_pos_p = PW'(req_position);

   // read port: pick the addressed cell
   always_comb begin
      rd_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (PW'(i) == rd_idx) rd_data = cell_q[i];
      end
   end

   // command decode and result formation
   always_comb begin
      ctl           = '0;
      cell_pos      = req_pos_p;
      rd_idx        = req_pos_p;
      count_in      = count_ff;
      busy_in       = busy_ff;
      dump_idx_in   = dump_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_data_in   = '0;
      rsp_last_in   = 1'b1;

      if (busy_ff) begin
         // dump walk, one entry a cycle
         rd_idx       = PW'(dump_idx_ff);
         rsp_valid_in = 1'b1;
         rsp_data_in  = rd_data;
         rsp_last_in  = (dump_idx_ff == CW'(count_ff - 1'b1));
         busy_in      = !rsp_last_in;
         dump_idx_in  = dump_idx_ff + 1'b1;
      end else if (accept) begin
         rsp_valid_in = 1'b1;
         case (req_command)
            CMD_APPEND: begin
               if (count_p >= DEPTH_P) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  ctl.ins     = 1'b1;
                  cell_pos    = count_p;
                  count_in    = count_ff + 1'b1;
                  rsp_data_in = req_value;
               end
            end
            CMD_INSERT: begin
               if (req_pos_p > count_p) begin
                  rsp_status_in = ST_RANGE;
               end else if (count_p >= DEPTH_P) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  ctl.ins     = 1'b1;
                  count_in    = count_ff + 1'b1;
                  rsp_data_in = req_value;
               end
            end
            CMD_POP_TAIL: begin
               rd_idx = PW'(count_ff - 1'b1);
               if (count_ff == '0) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  count_in    = count_ff - 1'b1;
                  rsp_data_in = rd_data;
               end
            end
            CMD_REMOVE_AT: begin
               if (count_ff == '0) begin
                  rsp_status_in = ST_EMPTY;
               end else if (req_pos_p >= count_p) begin
                  rsp_status_in = ST_RANGE;
               end else begin
                  ctl.del     = 1'b1;
                  count_in    = count_ff - 1'b1;
                  rsp_data_in = rd_data;
               end
            end
            CMD_REPLACE: begin
               if (count_ff == '0) begin
                  rsp_status_in = ST_EMPTY;
               end else if (req_pos_p >= count_p) begin
                  rsp_status_in = ST_RANGE;
               end else begin
                  ctl.wr      = 1'b1;
                  rsp_data_in = req_value;
               end
            end
            CMD_DUMP: begin
               rd_idx = '0;
               if (count_ff != '0) begin
                  rsp_data_in = rd_data;
                  rsp_last_in = (count_ff == CW'(1));
                  busy_in     = (count_ff > CW'(1));
                  dump_idx_in = CW'(1);
               end
            end
            default: begin
               // unused codes answer ok with no change
            end
         endcase
      end
      rsp_length_in = LEN_W'(count_in);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // row of cells, each wired to its neighbors
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
         assign cell_left[g] = '0;
      end else begin : g_mid_l
         assign cell_left[g] = cell_q[g-1];
      end
      if (g == DEPTH - 1) begin : g_final
         assign cell_right[g] = '0;
      end else begin : g_mid_r
         assign cell_right[g] = cell_q[g+1];
      end

      plh_cell #(
         .PW    (PW),
         .INDEX (g)
      ) u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .pos     (cell_pos),
         .value_i (req_value),
         .left_i  (cell_left[g]),
         .right_i (cell_right[g]),
         .entry_o (cell_q[g])
      );
   end

   assign busy       = busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_length = rsp_length_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_last   = rsp_last_ff;

`ifndef SYNTHESIS
   // list never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      PW'(count_ff) <= DEPTH_P)
      else $error("entry count above depth");

   // every accepted request gives a result on the next cycle
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request without result");

   // every dump cycle gives a result on the next cycle
   a_dump_result: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> rsp_valid_ff)
      else $error("dump cycle without result");

   // a result without last must come while busy still marks a dump in progress
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> busy_ff)
      else $error("unfinished result sequence without busy");
`endif

endmodule

`default_nettype wire
